// ----- rtl/ocr_pkg.sv -----
// Package for the overcurrent trip and retry block.
// Holds register indexes, register and result types. No dependencies.
package ocr_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_CURRENT_LIMIT = 3'd0;
   localparam csr_index_type CSR_TRIP_TIME     = 3'd1;
   localparam csr_index_type CSR_RETRY_DELAY   = 3'd2;
   localparam csr_index_type CSR_MAX_RETRIES   = 3'd3;
   localparam csr_index_type CSR_ALWAYS_RETRY  = 3'd4;

   localparam logic [7:0]  RESET_CURRENT_LIMIT = 8'd0;
   localparam logic [15:0] RESET_TRIP_TIME     = 16'd100;
   localparam logic [15:0] RESET_RETRY_DELAY   = 16'd1000;
   localparam logic [7:0]  RESET_MAX_RETRIES   = 8'd0;
   localparam logic [7:0]  COUNT_MAX           = 8'hFF;

   typedef struct packed {
      logic [7:0]  current_limit;
      logic [15:0] trip_time;
      logic [15:0] retry_delay;
      logic [7:0]  max_retries;
      logic        always_retry;
   } cfg_type;

   typedef struct packed {
      logic is_tripped;
      logic shutdown_now;
      logic retry_now;
   } result_type;

endpackage

// ----- rtl/ocr_req_if.sv -----
// Tick channel of the overcurrent trip and retry block.
// Carries valid, ready and one tick item. No dependencies.
interface ocr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] timestep_ms;
   logic [15:0] current_sample;

   modport source (output valid, output timestep_ms, output current_sample, input ready);
   modport sink   (input valid, input timestep_ms, input current_sample, output ready);
endinterface

// ----- rtl/ocr_rsp_if.sv -----
// Result channel of the overcurrent trip and retry block.
// Carries valid, ready and one result item. No dependencies.
interface ocr_rsp_if;
   logic valid;
   logic ready;
   logic is_tripped;
   logic shutdown_now;
   logic retry_now;

   modport source (output valid, output is_tripped, output shutdown_now, output retry_now,
                   input ready);
   modport sink   (input valid, input is_tripped, input shutdown_now, input retry_now,
                   output ready);
endinterface

// ----- rtl/ocr_csr_if.sv -----
// Register write channel of the overcurrent trip and retry block.
// Carries valid, ready, register index and write data. Depends on ocr_pkg.
interface ocr_csr_if;
   logic                                valid;
   logic                                ready;
   ocr_pkg::csr_index_type              index;
   logic [ocr_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ocr_fuse_core.sv -----
// Fuse state and one-tick update: overcurrent timer, retry timer, retry count, trip flag.
// Depends on ocr_pkg.
module ocr_fuse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [15:0]         timestep_ms,
   input  logic [15:0]         current_sample,
   input  ocr_pkg::cfg_type    cfg,
   output ocr_pkg::result_type result
);

   // Timers never hold a value at or above their 16-bit threshold, so 16 bits suffice.
   logic [15:0] oc_timer_ff, oc_timer_in;
   logic [15:0] rt_timer_ff, rt_timer_in;
   logic [7:0]  retry_count_ff, retry_count_in;
   logic        tripped_ff, tripped_in;

   logic        enabled;
   logic        over_limit;
   logic [16:0] oc_sum;
   logic [15:0] oc_dec;
   logic [16:0] oc_next;
   logic        trip;
   logic        allowed;
   logic [16:0] rt_sum;
   logic        release_hit;

   always_comb begin
      enabled     = (cfg.current_limit != 8'd0);
      over_limit  = (current_sample >= {cfg.current_limit, 8'd0});
      oc_sum      = {1'b0, oc_timer_ff} + {1'b0, timestep_ms};
      oc_dec      = (timestep_ms > oc_timer_ff) ? 16'd0 : oc_timer_ff - timestep_ms;
      oc_next     = over_limit ? oc_sum : {1'b0, oc_dec};
      trip        = (oc_next >= {1'b0, cfg.trip_time});
      allowed     = cfg.always_retry ||
                    ((cfg.max_retries != 8'd0) && (retry_count_ff < cfg.max_retries));
      rt_sum      = {1'b0, rt_timer_ff} + {1'b0, timestep_ms};
      release_hit = (rt_sum >= {1'b0, cfg.retry_delay});

      oc_timer_in    = oc_timer_ff;
      rt_timer_in    = rt_timer_ff;
      retry_count_in = retry_count_ff;
      tripped_in     = tripped_ff;
      result.shutdown_now = 1'b0;
      result.retry_now    = 1'b0;

      if (enabled) begin
         if (tripped_ff) begin
            if (allowed) begin
               if (release_hit) begin
                  tripped_in  = 1'b0;
                  rt_timer_in = 16'd0;
                  if (retry_count_ff != ocr_pkg::COUNT_MAX) begin
                     retry_count_in = retry_count_ff + 8'd1;
                  end
                  result.retry_now = 1'b1;
               end else begin
                  rt_timer_in = rt_sum[15:0];
               end
            end
         end else if (trip) begin
            tripped_in          = 1'b1;
            oc_timer_in         = 16'd0;
            result.shutdown_now = 1'b1;
         end else begin
            oc_timer_in = oc_next[15:0];
         end
      end
      result.is_tripped = tripped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_timer_ff    <= '0;
         rt_timer_ff    <= '0;
         retry_count_ff <= '0;
         tripped_ff     <= 1'b0;
      end else if (step) begin
         oc_timer_ff    <= oc_timer_in;
         rt_timer_ff    <= rt_timer_in;
         retry_count_ff <= retry_count_in;
         tripped_ff     <= tripped_in;
      end
   end

endmodule

// ----- rtl/overcurrent_trip_retry.sv -----
// Top level of the slow-blow electronic fuse with automatic retry.
// Depends on ocr_pkg, ocr_req_if, ocr_rsp_if, ocr_csr_if and ocr_fuse_core.
//
// Usage:
//  - req_bus carries one tick per transfer: elapsed milliseconds and a current
//    sample in unsigned Q8.8 amps. rsp_bus returns exactly one result per tick,
//    in order: the tripped flag after the tick, a shutdown pulse on the tick that
//    trips and a retry pulse on the tick that releases the trip.
//  - csr_bus writes one register per transfer (index 0 current limit, 1 trip time,
//    2 retry delay, 3 max retries, 4 always retry); it is always ready and an
//    unknown index is dropped. Write registers only while no tick is in flight.
//  - Path: a transferred tick is held in the input register, is evaluated by the
//    fuse core as it advances into the result register, and is presented from there.
//  - Throughput: one tick per cycle while rsp_bus is ready. The input and result
//    registers form a two-stage pipe, so a tick is taken while a finished result waits.
//  - Stall: when rsp_bus is not ready the result holds, the input register fills
//    and then req_bus ready drops until the result is taken.
//  - Reset: clears the fuse state, empties both stages and loads the register
//    reset values (limit 0, which freezes the fuse; trip time 100; delay 1000).
module overcurrent_trip_retry (
   input  logic  clock,
   input  logic  reset,
   ocr_req_if.sink   req_bus,
   ocr_rsp_if.source rsp_bus,
   ocr_csr_if.sink   csr_bus
);

   ocr_pkg::cfg_type    cfg_ff;
   ocr_pkg::result_type core_result;
   ocr_pkg::result_type out_data_ff;

   logic        in_valid_ff;
   logic [15:0] in_ts_ff;
   logic [15:0] in_cur_ff;
   logic        out_valid_ff;
   logic        advance;

   // Move the held tick into the result register when that register is free
   // or is being emptied in this cycle.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   // Register writes: mask to width by taking the low bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_limit <= ocr_pkg::RESET_CURRENT_LIMIT;
         cfg_ff.trip_time     <= ocr_pkg::RESET_TRIP_TIME;
         cfg_ff.retry_delay   <= ocr_pkg::RESET_RETRY_DELAY;
         cfg_ff.max_retries   <= ocr_pkg::RESET_MAX_RETRIES;
         cfg_ff.always_retry  <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            ocr_pkg::CSR_CURRENT_LIMIT: cfg_ff.current_limit <= csr_bus.data[7:0];
            ocr_pkg::CSR_TRIP_TIME:     cfg_ff.trip_time     <= csr_bus.data;
            ocr_pkg::CSR_RETRY_DELAY:   cfg_ff.retry_delay   <= csr_bus.data;
            ocr_pkg::CSR_MAX_RETRIES:   cfg_ff.max_retries   <= csr_bus.data[7:0];
            ocr_pkg::CSR_ALWAYS_RETRY:  cfg_ff.always_retry  <= csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   // Input stage: hold the accepted tick until it advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_ts_ff  <= req_bus.timestep_ms;
         in_cur_ff <= req_bus.current_sample;
      end
   end

   // Fuse state advances exactly once per tick, as the tick enters the result stage.
   ocr_fuse_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .timestep_ms    (in_ts_ff),
      .current_sample (in_cur_ff),
      .cfg            (cfg_ff),
      .result         (core_result)
   );

   // Result stage: hold the result while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.is_tripped   = out_data_ff.is_tripped;
   assign rsp_bus.shutdown_now = out_data_ff.shutdown_now;
   assign rsp_bus.retry_now    = out_data_ff.retry_now;

   // A trip pulse leaves the fuse tripped, a retry pulse leaves it released.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.shutdown_now |-> out_data_ff.is_tripped)
      else $error("shutdown pulse without tripped flag");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.retry_now |-> !out_data_ff.is_tripped)
      else $error("retry pulse while still tripped");

   // Input backpressure only while a full pipe meets a stalled receiver.
   assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> in_valid_ff && out_valid_ff && !rsp_bus.ready)
      else $error("tick refused without a stall");

   // Every tick that advances appears as a result at the next edge.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced tick lost");

   // A tick in the input stage with a free result stage must advance.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |-> advance)
      else $error("tick held with free result stage");

endmodule

// ----- dv/ocr_fuse_checker.sv -----
// Checker for the overcurrent trip and retry block: predicts each result and compares it.
// Depends on ocr_pkg; watches the tick, result and register write channels as plain signals.
module ocr_fuse_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_valid,
   input  logic                   tick_ready,
   input  logic [15:0]            tick_timestep_ms,
   input  logic [15:0]            tick_current_sample,
   input  logic                   result_valid,
   input  logic                   result_ready,
   input  logic                   result_is_tripped,
   input  logic                   result_shutdown_now,
   input  logic                   result_retry_now,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  ocr_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_data,
   output int unsigned            pending_results,
   output int unsigned            mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   ocr_pkg::cfg_type     fuse_cfg;
   logic [31:0]          blow_timer;
   logic [31:0]          release_timer;
   logic [7:0]           retries_used;
   logic                 fuse_open;
   ocr_pkg::result_type  awaited_results[$];
   int unsigned          mismatches = 0;
   int unsigned          awaited_total = 0;

   assign pending_results = awaited_total;
   assign mismatch_count  = mismatches;

   function automatic logic [31:0] add_saturating(logic [31:0] acc, logic [15:0] step);
      logic [32:0] sum;
      sum = {1'b0, acc} + 33'(step);
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic int unsigned field_differs(string field, logic want, logic got);
      if (want !== got) begin
         $error("%s mismatch: expected %0b, actual %0b", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   // advance the fuse by one tick and return the result it reports
   task automatic advance_fuse(input logic [15:0] step_ms, input logic [15:0] amps_q8,
                               output ocr_pkg::result_type res);
      logic may_retry;
      res = '0;
      if (fuse_cfg.current_limit != 8'd0) begin
         if (fuse_open) begin
            may_retry = fuse_cfg.always_retry ||
                        (fuse_cfg.max_retries != 8'd0 && retries_used < fuse_cfg.max_retries);
            if (may_retry) begin
               release_timer = add_saturating(release_timer, step_ms);
               if (release_timer >= 32'(fuse_cfg.retry_delay)) begin
                  fuse_open     = 1'b0;
                  release_timer = '0;
                  if (retries_used != ocr_pkg::COUNT_MAX) retries_used = retries_used + 8'd1;
                  res.retry_now = 1'b1;
               end
            end
         end else begin
            if (amps_q8 >= {fuse_cfg.current_limit, 8'h00})
               blow_timer = add_saturating(blow_timer, step_ms);
            else if (32'(step_ms) > blow_timer)
               blow_timer = '0;
            else
               blow_timer = blow_timer - 32'(step_ms);
            if (blow_timer >= 32'(fuse_cfg.trip_time)) begin
               fuse_open        = 1'b1;
               blow_timer       = '0;
               res.shutdown_now = 1'b1;
            end
         end
      end
      res.is_tripped = fuse_open;
   endtask

   always @(posedge clock) begin : watch
      ocr_pkg::result_type want;
      if (reset) begin
         fuse_cfg.current_limit = ocr_pkg::RESET_CURRENT_LIMIT;
         fuse_cfg.trip_time     = ocr_pkg::RESET_TRIP_TIME;
         fuse_cfg.retry_delay   = ocr_pkg::RESET_RETRY_DELAY;
         fuse_cfg.max_retries   = ocr_pkg::RESET_MAX_RETRIES;
         fuse_cfg.always_retry  = 1'b0;
         blow_timer    = '0;
         release_timer = '0;
         retries_used  = '0;
         fuse_open     = 1'b0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ocr_pkg::CSR_CURRENT_LIMIT: fuse_cfg.current_limit = csr_data[7:0];
               ocr_pkg::CSR_TRIP_TIME:     fuse_cfg.trip_time     = csr_data;
               ocr_pkg::CSR_RETRY_DELAY:   fuse_cfg.retry_delay   = csr_data;
               ocr_pkg::CSR_MAX_RETRIES:   fuse_cfg.max_retries   = csr_data[7:0];
               ocr_pkg::CSR_ALWAYS_RETRY:  fuse_cfg.always_retry  = csr_data[0];
               default: ;
            endcase
         end
         if (tick_valid && tick_ready) begin
            advance_fuse(tick_timestep_ms, tick_current_sample, want);
            awaited_results.push_back(want);
         end
         if (result_valid && result_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result transfer with no tick outstanding");
               mismatches = mismatches + 1;
            end else begin
               want = awaited_results.pop_front();
               mismatches = mismatches
                  + field_differs("is_tripped", want.is_tripped, result_is_tripped)
                  + field_differs("shutdown_now", want.shutdown_now, result_shutdown_now)
                  + field_differs("retry_now", want.retry_now, result_retry_now);
            end
         end
      end
      awaited_total <= awaited_results.size();
   end

endmodule

// ----- dv/overcurrent_trip_retry_tb.sv -----
// Testbench top for the overcurrent trip and retry block: drives ticks, register writes and
// result back-pressure, and gives the verdict. Depends on ocr_pkg, the three channel
// interfaces, overcurrent_trip_retry and ocr_fuse_checker.
module overcurrent_trip_retry_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        calm;          // last part of the run: no idling on either side
   int unsigned gap_odds;      // one sender gap per this many ticks, zero for none
   int unsigned pending_results;
   int unsigned mismatch_count;

   ocr_req_if req_bus ();
   ocr_rsp_if rsp_bus ();
   ocr_csr_if csr_bus ();

   overcurrent_trip_retry uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   ocr_fuse_checker fuse_monitor (
      .clock               (clock),
      .reset               (reset),
      .tick_valid          (req_bus.valid),
      .tick_ready          (req_bus.ready),
      .tick_timestep_ms    (req_bus.timestep_ms),
      .tick_current_sample (req_bus.current_sample),
      .result_valid        (rsp_bus.valid),
      .result_ready        (rsp_bus.ready),
      .result_is_tripped   (rsp_bus.is_tripped),
      .result_shutdown_now (rsp_bus.shutdown_now),
      .result_retry_now    (rsp_bus.retry_now),
      .csr_valid           (csr_bus.valid),
      .csr_ready           (csr_bus.ready),
      .csr_index           (csr_bus.index),
      .csr_data            (csr_bus.data),
      .pending_results     (pending_results),
      .mismatch_count      (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: the slowest correct run is well under a tenth of this.
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Result side back-pressure: a stall burst, then a run of ready cycles, over and over.
   // Long runs give stretches without any stall.
   initial begin : result_sink
      int unsigned stall_left;
      int unsigned run_left;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = stall_left - 1;
         end else if (run_left != 0) begin
            rsp_bus.ready <= 1'b1;
            run_left = run_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            run_left   = $urandom_range(0, 40);
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 18);
         end
      end
   end

   // Offer one tick and hold it until the transfer. An optional gap comes first; without one,
   // valid stays high from the previous tick so it is never lowered and raised in one step.
   task automatic send_tick(input logic [15:0] step_ms, input logic [15:0] amps_q8);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.timestep_ms    <= step_ms;
      req_bus.current_sample <= amps_q8;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and hold off until every predicted result has come back.
   // Sample the count at the falling edge, away from the checker's updates.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (3) @(posedge clock);
   endtask

   // Write the whole register set with the block idle. Upper bits beyond each register's width
   // carry noise, and one of the unused indexes gets a write that must be dropped.
   task automatic apply_setting(input ocr_pkg::cfg_type s);
      ocr_pkg::csr_index_type spare;
      drain_results();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= ocr_pkg::CSR_CURRENT_LIMIT;
      csr_bus.data  <= {8'($urandom), s.current_limit};
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= ocr_pkg::CSR_TRIP_TIME;
      csr_bus.data  <= s.trip_time;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= ocr_pkg::CSR_RETRY_DELAY;
      csr_bus.data  <= s.retry_delay;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= ocr_pkg::CSR_MAX_RETRIES;
      csr_bus.data  <= {8'($urandom), s.max_retries};
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= ocr_pkg::CSR_ALWAYS_RETRY;
      csr_bus.data  <= {15'($urandom), s.always_retry};
      do @(posedge clock); while (!csr_bus.ready);
      spare = ocr_pkg::csr_index_type'(ocr_pkg::CSR_ALWAYS_RETRY + 3'($urandom_range(1, 3)));
      csr_bus.index <= spare;
      csr_bus.data  <= 16'($urandom);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : stimulus
      ocr_pkg::cfg_type phase_cfg;
      int unsigned      roll;
      int unsigned      span;
      int unsigned      threshold;
      int unsigned      amps;
      logic [15:0]      step_ms;

      reset                  = 1'b1;
      calm                   = 1'b0;
      gap_odds               = 0;
      req_bus.valid          = 1'b0;
      req_bus.timestep_ms    = '0;
      req_bus.current_sample = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = ocr_pkg::CSR_CURRENT_LIMIT;
      csr_bus.data           = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Reset values: zero limit freezes the fuse whatever the tick says.
      send_tick(16'hFFFF, 16'hFFFF);
      send_tick(16'd0, 16'd0);

      // 4 A limit, 100 ms to trip, 50 ms retry delay, two retries.
      phase_cfg = '{current_limit: 8'd4, trip_time: 16'd100, retry_delay: 16'd50,
                    max_retries: 8'd2, always_retry: 1'b0};
      apply_setting(phase_cfg);
      send_tick(16'd60, 16'd1024);     // exactly at the limit: accumulate
      send_tick(16'd20, 16'd1023);     // just below: bleed off
      send_tick(16'hFFFF, 16'd0);      // bleed past zero: floor
      send_tick(16'd99, 16'hFFFF);     // one short of the trip time
      send_tick(16'd1, 16'd1024);      // reach it: shut down
      send_tick(16'd49, 16'd0);
      send_tick(16'd1, 16'd0);         // first retry
      send_tick(16'd100, 16'd2000);
      send_tick(16'hFFFF, 16'd0);      // second retry
      send_tick(16'd100, 16'd1024);
      send_tick(16'hFFFF, 16'd0);      // retries used up: stay tripped

      // Disable while tripped: the flag holds and nothing pulses.
      phase_cfg = '{current_limit: 8'd0, trip_time: 16'd100, retry_delay: 16'd50,
                    max_retries: 8'd2, always_retry: 1'b1};
      apply_setting(phase_cfg);
      send_tick(16'hFFFF, 16'hFFFF);

      // Zero trip time and zero retry delay with always retry.
      phase_cfg = '{current_limit: 8'd255, trip_time: 16'd0, retry_delay: 16'd0,
                    max_retries: 8'd0, always_retry: 1'b1};
      apply_setting(phase_cfg);
      send_tick(16'd0, 16'd0);
      send_tick(16'd0, 16'd0);
      send_tick(16'd0, 16'hFF00);
      send_tick(16'd0, 16'hFEFF);

      // Widest timers and the smallest limit.
      phase_cfg = '{current_limit: 8'd1, trip_time: 16'hFFFF, retry_delay: 16'hFFFF,
                    max_retries: 8'd255, always_retry: 1'b0};
      apply_setting(phase_cfg);
      send_tick(16'hFFFF, 16'h0100);
      send_tick(16'hFFFF, 16'h0100);
      send_tick(16'hFFFE, 16'd0);
      send_tick(16'd1, 16'd0);

      // Random part: several settings, each drained before the next. Current is biased around
      // the threshold and steps are scaled to the timers so that trips and retries happen.
      for (int phase = 0; phase < 6; phase++) begin
         roll = $urandom_range(0, 7);
         phase_cfg.current_limit = (roll == 0) ? 8'd1 : (roll == 1) ? 8'd255 :
                                   (roll == 2) ? 8'd0 : 8'($urandom_range(1, 255));
         roll = $urandom_range(0, 7);
         phase_cfg.trip_time   = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF :
                                 16'($urandom_range(1, 400));
         roll = $urandom_range(0, 7);
         phase_cfg.retry_delay = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF :
                                 16'($urandom_range(1, 400));
         roll = $urandom_range(0, 7);
         phase_cfg.max_retries = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 :
                                 8'($urandom_range(1, 6));
         phase_cfg.always_retry = 1'($urandom_range(0, 1));
         apply_setting(phase_cfg);
         gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);

         span = (phase_cfg.trip_time > phase_cfg.retry_delay) ?
                32'(phase_cfg.trip_time) : 32'(phase_cfg.retry_delay);
         span = span / 3 + 16;
         threshold = 32'({phase_cfg.current_limit, 8'h00});
         for (int n = 0; n < 40; n++) begin
            roll = $urandom_range(0, 9);
            step_ms = (roll == 0) ? 16'($urandom) : (roll == 1) ? 16'd0 :
                      16'($urandom_range(0, span));
            roll = $urandom_range(0, 19);
            if (roll < 9) begin
               amps = threshold + $urandom_range(0, 600);
               if (amps > 32'hFFFF) amps = 32'hFFFF;
            end else if (roll < 15) begin
               amps = (threshold == 0) ? 0 :
                      threshold - $urandom_range(1, (threshold < 600) ? threshold : 600);
            end else if (roll < 18) begin
               amps = $urandom_range(0, 16'hFFFF);
            end else begin
               amps = (roll == 18) ? 0 : 16'hFFFF;
            end
            send_tick(step_ms, 16'(amps));
         end
      end

      // Last part, no idling: zero timers with always retry alternate trip and release on
      // every tick, so the retry count climbs well past any small limit.
      phase_cfg = '{current_limit: 8'($urandom_range(1, 255)), trip_time: 16'd0,
                    retry_delay: 16'd0, max_retries: 8'd0, always_retry: 1'b1};
      apply_setting(phase_cfg);
      calm     <= 1'b1;
      gap_odds = 0;
      for (int n = 0; n < 170; n++) send_tick(16'($urandom), 16'($urandom));

      // A retry limit that the count has already passed: the fuse latches.
      phase_cfg.max_retries  = 8'd1;
      phase_cfg.always_retry = 1'b0;
      apply_setting(phase_cfg);
      for (int n = 0; n < 10; n++) send_tick(16'($urandom), 16'($urandom));

      drain_results();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
